// ===== rtl/core/vsph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vsph_pkg;

    localparam int SqrtCells = 32;
    localparam int DivCells  = 31;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;
    localparam logic [1:0] REG_RADIUS   = 2'd3;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] norm_in_x;
        logic signed [31:0] norm_in_y;
        logic signed [31:0] norm_in_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_norm_x;
        logic signed [31:0] out_norm_y;
        logic signed [31:0] out_norm_z;
        logic               was_moved;
    } out_word_t;

    typedef struct packed {
        logic              zero;
        logic [2:0]        neg;
        logic [2:0][31:0]  nin;
    } side_t;

    typedef struct packed {
        logic              valid;
        side_t             side;
        logic [63:0]       rad;
        logic [34:0]       rem;
        logic [31:0]       root;
        logic [2:0][30:0]  a;
    } sq_t;

    typedef struct packed {
        logic              valid;
        side_t             side;
        logic [31:0]       len;
        logic [2:0][62:0]  lane;
    } dv_t;

    function automatic logic [4:0] lz31(input logic [30:0] v);
        logic [4:0] cnt;
        cnt = 5'd0;
        for (int i = 0; i < 31; i++) begin
            if (v[i]) begin
                cnt = 5'(30 - i);
            end
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vsph_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vsph_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  vsph_pkg::in_word_t       in_word,
    input  wire logic [2:0][31:0]    center,
    output vsph_pkg::sq_t            sq_out
);
    import vsph_pkg::*;

    logic [4:0]        v_reg;
    side_t             side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    logic [2:0][31:0]  mag1_reg, mag2_reg;
    logic [31:0]       max2_reg;
    logic [2:0][30:0]  a3_reg, a4_reg, a5_reg;
    logic [2:0][61:0]  sq4_reg;
    logic [63:0]       sum5_reg;

    logic [2:0][31:0]  pos;
    logic [2:0][32:0]  diff;
    logic [2:0][31:0]  mag_next;
    side_t             side_next;
    logic [31:0]       max_next;
    logic [4:0]        sh;
    logic [2:0][30:0]  a_next;

    always_comb begin
        pos[0] = in_word.pos_x;
        pos[1] = in_word.pos_y;
        pos[2] = in_word.pos_z;
        side_next.nin[0] = in_word.norm_in_x;
        side_next.nin[1] = in_word.norm_in_y;
        side_next.nin[2] = in_word.norm_in_z;
        for (int i = 0; i < 3; i++) begin
            diff[i] = {pos[i][31], pos[i]} - {center[i][31], center[i]};
            side_next.neg[i] = diff[i][32];
            mag_next[i] = diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
        end
        side_next.zero = (diff[0] == 33'd0) && (diff[1] == 33'd0) && (diff[2] == 33'd0);

        max_next = mag1_reg[0];
        if (mag1_reg[1] > max_next) begin
            max_next = mag1_reg[1];
        end
        if (mag1_reg[2] > max_next) begin
            max_next = mag1_reg[2];
        end

        sh = lz31(max2_reg[30:0]);
        for (int i = 0; i < 3; i++) begin
            if (max2_reg[31]) begin
                a_next[i] = mag2_reg[i][31:1];
            end else begin
                a_next[i] = 31'(mag2_reg[i] << sh);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
        if (en) begin
            side1_reg <= side_next;
            mag1_reg  <= mag_next;
            side2_reg <= side1_reg;
            mag2_reg  <= mag1_reg;
            max2_reg  <= max_next;
            side3_reg <= side2_reg;
            a3_reg    <= a_next;
            side4_reg <= side3_reg;
            a4_reg    <= a3_reg;
            for (int i = 0; i < 3; i++) begin
                sq4_reg[i] <= 62'(a3_reg[i]) * 62'(a3_reg[i]);
            end
            side5_reg <= side4_reg;
            a5_reg    <= a4_reg;
            sum5_reg  <= 64'(sq4_reg[0]) + 64'(sq4_reg[1]) + 64'(sq4_reg[2]);
        end
    end

    always_comb begin
        sq_out.valid = v_reg[4];
        sq_out.side  = side5_reg;
        sq_out.rad   = sum5_reg;
        sq_out.rem   = '0;
        sq_out.root  = '0;
        sq_out.a     = a5_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/core/vsph_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vsph_sqrt_cell (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  vsph_pkg::sq_t cell_in,
    output vsph_pkg::sq_t cell_out
);
    import vsph_pkg::*;

    sq_t         cell_reg, cell_next;
    logic [34:0] rem_sh;
    logic [34:0] trial;

    always_comb begin
        cell_next = cell_in;
        rem_sh = {cell_in.rem[32:0], cell_in.rad[63:62]};
        trial  = {1'b0, cell_in.root, 2'b01};
        cell_next.rad = {cell_in.rad[61:0], 2'b00};
        if (rem_sh >= trial) begin
            cell_next.rem  = rem_sh - trial;
            cell_next.root = {cell_in.root[30:0], 1'b1};
        end else begin
            cell_next.rem  = rem_sh;
            cell_next.root = {cell_in.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vsph_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vsph_div_cell (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  vsph_pkg::dv_t cell_in,
    output vsph_pkg::dv_t cell_out
);
    import vsph_pkg::*;

    dv_t              cell_reg, cell_next;
    logic [2:0][32:0] t;
    logic [2:0][32:0] dif;
    logic [2:0]       ge;
    logic [2:0][31:0] rem_n;

    always_comb begin
        cell_next = cell_in;
        for (int i = 0; i < 3; i++) begin
            t[i]   = {cell_in.lane[i][62:31], cell_in.lane[i][30]};
            dif[i] = t[i] - {1'b0, cell_in.len};
            ge[i]  = t[i] >= {1'b0, cell_in.len};
            rem_n[i] = ge[i] ? dif[i][31:0] : t[i][31:0];
            cell_next.lane[i] = {rem_n[i], cell_in.lane[i][29:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vertex_spherify.sv =====
`timescale 1ns / 1ps
`default_nettype none

// projects one vertex per word onto a sphere of configured center and radius. a new word is
// taken every cycle unless the output is held; each word passes through five setup
// stages (offset, range, scaling, squares, sum), 32 square root cells giving one root bit each,
// 31 divider cells giving one normal bit each, one radius multiply and the output register.
// a held output stalls the whole row. configuration must be written only while the block is empty.

module vertex_spherify (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output wire logic            s_ready,
    input  vsph_pkg::in_word_t   s_data,
    output wire logic            m_valid,
    input  wire logic            m_ready,
    output vsph_pkg::out_word_t  m_data,
    input  wire logic            cfg_we,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [31:0]     cfg_wdata
);
    import vsph_pkg::*;

    logic [2:0][31:0] center_reg;
    logic [30:0]      radius_reg;
    logic             m_valid_reg;
    out_word_t        m_data_reg, m_data_next;
    logic             en;

    sq_t              sq_chain [SqrtCells+1];
    dv_t              dv_chain [DivCells+1];

    logic             vm_reg;
    side_t            sidem_reg;
    logic [2:0][61:0] prod_reg;
    logic [2:0][30:0] nout_q_reg;

    logic [2:0][62:0] rnd;
    logic [2:0][32:0] off;
    logic [2:0][34:0] p;
    logic [2:0][31:0] psat;
    logic [2:0][31:0] nout;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= '0;
            radius_reg <= 31'd65536;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CENTER_X: center_reg[0] <= cfg_wdata;
                REG_CENTER_Y: center_reg[1] <= cfg_wdata;
                REG_CENTER_Z: center_reg[2] <= cfg_wdata;
                REG_RADIUS:   radius_reg    <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    vsph_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_word  (s_data),
        .center   (center_reg),
        .sq_out   (sq_chain[0])
    );

    for (genvar k = 0; k < SqrtCells; k++) begin : g_sqrt
        vsph_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (sq_chain[k]),
            .cell_out (sq_chain[k+1])
        );
    end

    always_comb begin
        dv_chain[0].valid = sq_chain[SqrtCells].valid;
        dv_chain[0].side  = sq_chain[SqrtCells].side;
        dv_chain[0].len   = sq_chain[SqrtCells].root;
        for (int i = 0; i < 3; i++) begin
            dv_chain[0].lane[i] = {2'b00, sq_chain[SqrtCells].a[i], 30'd0}
                                + {32'd0, sq_chain[SqrtCells].root[31:1]};
        end
    end

    for (genvar k = 0; k < DivCells; k++) begin : g_div
        vsph_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (dv_chain[k]),
            .cell_out (dv_chain[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (en) begin
            vm_reg <= dv_chain[DivCells].valid;
        end
        if (en) begin
            sidem_reg <= dv_chain[DivCells].side;
            for (int i = 0; i < 3; i++) begin
                nout_q_reg[i] <= dv_chain[DivCells].lane[i][30:0];
                prod_reg[i]   <= 62'(radius_reg) * 62'(dv_chain[DivCells].lane[i][30:0]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i] = {1'b0, prod_reg[i]} + (63'd1 << 29);
            off[i] = rnd[i][62:30];
            if (sidem_reg.neg[i]) begin
                p[i] = {{3{center_reg[i][31]}}, center_reg[i]} - {2'b00, off[i]};
                nout[i] = 32'(-{1'b0, nout_q_reg[i]});
            end else begin
                p[i] = {{3{center_reg[i][31]}}, center_reg[i]} + {2'b00, off[i]};
                nout[i] = {1'b0, nout_q_reg[i]};
            end
            if (!p[i][34] && (p[i][33:31] != 3'b000)) begin
                psat[i] = 32'h7fff_ffff;
            end else if (p[i][34] && (p[i][33:31] != 3'b111)) begin
                psat[i] = 32'h8000_0000;
            end else begin
                psat[i] = p[i][31:0];
            end
        end
        if (sidem_reg.zero) begin
            m_data_next.out_pos_x  = center_reg[0];
            m_data_next.out_pos_y  = center_reg[1];
            m_data_next.out_pos_z  = center_reg[2];
            m_data_next.out_norm_x = sidem_reg.nin[0];
            m_data_next.out_norm_y = sidem_reg.nin[1];
            m_data_next.out_norm_z = sidem_reg.nin[2];
            m_data_next.was_moved  = 1'b0;
        end else begin
            m_data_next.out_pos_x  = psat[0];
            m_data_next.out_pos_y  = psat[1];
            m_data_next.out_pos_z  = psat[2];
            m_data_next.out_norm_x = nout[0];
            m_data_next.out_norm_y = nout[1];
            m_data_next.out_norm_z = nout[2];
            m_data_next.was_moved  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vm_reg;
        end
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vsph_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vsph_checker (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_ready,
    input  wire logic            m_valid,
    input  wire logic            m_ready,
    input  vsph_pkg::out_word_t  m_data
);

    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data);
    endproperty
    a_hold: assert property (p_hold) else $error("output word changed while stalled");

    property p_reset;
        @(posedge aclk) !aresetn |=> !m_valid;
    endproperty
    a_reset: assert property (p_reset) else $error("output valid after reset");

    property p_ready;
        @(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready;
    endproperty
    a_ready: assert property (p_ready) else $error("input stalled with empty output");

    property p_unit;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.was_moved |->
            (m_data.out_norm_x <= 32'sd1073741824) && (m_data.out_norm_x >= -32'sd1073741824)
            && (m_data.out_norm_y <= 32'sd1073741824)
            && (m_data.out_norm_y >= -32'sd1073741824)
            && (m_data.out_norm_z <= 32'sd1073741824)
            && (m_data.out_norm_z >= -32'sd1073741824);
    endproperty
    a_unit: assert property (p_unit) else $error("normal component beyond one");

endmodule

bind vertex_spherify vsph_checker u_vsph_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
